[src/lag_pkg.sv]
// ----------------------------------------------------------------------------
// lag_pkg
// types and constants shared by the life automaton generation block
// ----------------------------------------------------------------------------
package lag_pkg;

    localparam int unsigned BoardWidthDefault  = 64;
    localparam int unsigned BoardHeightDefault = 64;
    localparam int unsigned CoordW             = 6;
    localparam int unsigned CountW             = 13;
    localparam int unsigned FadeW              = 8;
    localparam int unsigned CfgIdxW            = 1;
    localparam logic [CountW-1:0] CountMax     = 13'h1fff;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DEAD    = 2'd0,
        ST_LIVE    = 2'd1,
        ST_NEWBORN = 2'd2,
        ST_DYING   = 2'd3
    } t_cell;

    localparam logic [CfgIdxW-1:0] REG_FADE_BRIGHT = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_FADE_DARK   = 1'd1;

    typedef struct packed {
        logic [1:0]        command;
        logic [CoordW-1:0] cell_x;
        logic [CoordW-1:0] cell_y;
        logic              cell_alive;
    } t_in;

    typedef struct packed {
        logic [1:0]        cell_state;
        logic [FadeW-1:0]  fade_level;
        logic [CountW-1:0] births;
        logic [CountW-1:0] deaths;
    } t_out;

    // per-cell handshake from the sequencer to the cell chain
    typedef struct packed {
        logic              shift;
        logic              first_row;
        logic              last_row;
        logic              first_col;
        logic              last_col;
    } t_sweep;

endpackage

[src/lag_if.sv]
// ----------------------------------------------------------------------------
// lag_if
// valid/ready channel carrying one transaction of a packed payload
// ----------------------------------------------------------------------------
interface lag_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/lag_cell.sv]
// ----------------------------------------------------------------------------
// lag_cell
// one neighbourhood cell of the chain: a 3x3 window position that, while shift is high,
// takes the snapshot bit handed from its neighbour and registers it each cycle
// ----------------------------------------------------------------------------
module lag_cell (
    input  logic i_clk,
    input  logic i_shift,
    input  logic i_bit,
    output logic o_bit
);
    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_bit <= i_bit;
        end
    end

    assign o_bit = r_bit;
endmodule

[src/lag_core.sv]
// ----------------------------------------------------------------------------
// lag_core
// board memories, row line buffers, window chain of cells and sequencer
// ----------------------------------------------------------------------------
module lag_core #(
    parameter int unsigned BOARD_WIDTH  = lag_pkg::BoardWidthDefault,
    parameter int unsigned BOARD_HEIGHT = lag_pkg::BoardHeightDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lag_pkg::FadeW-1:0]   i_fade_bright,
    input  logic [lag_pkg::FadeW-1:0]   i_fade_dark,
    lag_if.sink                         in_ch,
    lag_if.source                       out_ch
);
    import lag_pkg::*;

    localparam int unsigned Cells = BOARD_WIDTH * BOARD_HEIGHT;
    localparam int unsigned AddrW = $clog2(Cells);
    localparam int unsigned XW    = $clog2(BOARD_WIDTH);
    localparam int unsigned YW    = $clog2(BOARD_HEIGHT);
    localparam int unsigned PosW  = AddrW + 1;
    localparam logic [PosW-1:0] LastPos = PosW'(Cells - 1);
    localparam logic [PosW-1:0] Lag     = PosW'(BOARD_WIDTH + 1);
    localparam logic [PosW-1:0] EndPos  = PosW'(Cells + BOARD_WIDTH + 3);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLEAR  = 6'b000010,
        S_SETTLE = 6'b000100,
        S_SWEEP  = 6'b001000,
        S_ACCESS = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // board memories
    logic [1:0]       cell_mem [Cells];
    logic [FadeW-1:0] fade_mem [Cells];
    logic             snap_mem [Cells];

    t_in              r_req;
    logic [PosW-1:0]  r_pos;      // settle / sweep counter
    logic [AddrW-1:0] r_clr;
    logic [CountW-1:0] r_births, r_deaths, r_bcnt, r_dcnt;
    logic             r_out_valid;
    t_out             r_out;

    // read pipeline
    logic [1:0]       r_rd_cell;
    logic [FadeW-1:0] r_rd_fade;
    logic             r_rd_snap;
    logic             r_rd_v;
    logic [AddrW-1:0] r_rd_addr;

    // two row line buffers, snapshot bits delayed by one and two rows
    logic             line1 [BOARD_WIDTH];
    logic             line2 [BOARD_WIDTH];
    logic [XW-1:0]    r_lx;
    logic             r_l1q, r_l2q;

    // window: three rows of three cells each, a chain of lag_cell
    logic [2:0]       win_in [3];
    logic [2:0]       win    [3];
    logic             r_win_v;
    logic [XW-1:0]    r_cx;
    logic [YW-1:0]    r_cy;
    logic [AddrW-1:0] r_caddr;
    logic             r_cv;

    logic             on_board;
    logic [AddrW-1:0] req_addr;
    logic             fin;

    t_sweep sw;

    assign on_board = (32'(r_req.cell_x) < BOARD_WIDTH) && (32'(r_req.cell_y) < BOARD_HEIGHT);
    assign req_addr = AddrW'(32'(r_req.cell_y) * BOARD_WIDTH + 32'(r_req.cell_x));

    assign in_ch.ready = (r_state == S_IDLE) && !r_out_valid;
    assign out_ch.valid   = r_out_valid;
    assign out_ch.payload = r_out;

    // sweep feed: snapshot read at r_pos, one cell per cycle
    logic             feed_v;
    logic             feed_bit;
    assign feed_v   = (r_state == S_SWEEP) && r_rd_v;
    assign feed_bit = feed_v ? r_rd_snap : 1'b0;

    always_ff @(posedge i_clk) begin
        if (r_state == S_SWEEP) begin
            r_rd_snap <= (r_pos < PosW'(Cells)) ? snap_mem[r_pos[AddrW-1:0]] : 1'b0;
        end
        if (r_state == S_SETTLE && r_pos < PosW'(Cells)) begin
            r_rd_cell <= cell_mem[r_pos[AddrW-1:0]];
        end else if (r_state == S_ACCESS) begin
            r_rd_cell <= cell_mem[req_addr];
        end
        if (r_state == S_ACCESS) begin
            r_rd_fade <= fade_mem[req_addr];
        end
    end

    // line buffers shift on every sweep cycle
    assign sw.shift     = (r_state == S_SWEEP);
    assign sw.first_row = 1'b0;
    assign sw.last_row  = 1'b0;
    assign sw.first_col = 1'b0;
    assign sw.last_col  = 1'b0;

    logic [XW-1:0] lx_next;
    assign lx_next = (32'(r_lx) == BOARD_WIDTH - 1) ? '0 : r_lx + XW'(1);

    // registered read one position ahead of the write
    always_ff @(posedge i_clk) begin
        if (sw.shift) begin
            line1[r_lx] <= feed_bit;
            line2[r_lx] <= r_l1q;
            r_l1q       <= line1[lx_next];
            r_l2q       <= line2[lx_next];
        end
    end

    assign win_in[0] = {win[0][1:0], feed_bit};
    assign win_in[1] = {win[1][1:0], r_l1q};
    assign win_in[2] = {win[2][1:0], r_l2q};

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            lag_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (sw.shift),
                .i_bit   (win_in[r][c]),
                .o_bit   (win[r][c])
            );
        end
    end

    // centre of window: row 1, column 1; position of centre lags feed by W+1
    logic [PosW-1:0] cpos;
    assign cpos = r_pos - Lag - PosW'(1);
    logic cx_lo, cx_hi, cy_lo, cy_hi;
    assign cx_lo = (r_cx == '0);
    assign cx_hi = (32'(r_cx) == BOARD_WIDTH - 1);
    assign cy_lo = (r_cy == '0);
    assign cy_hi = (32'(r_cy) == BOARD_HEIGHT - 1);

    logic [3:0] ncount;
    always_comb begin
        logic n0, n1, n2, n3, n5, n6, n7, n8;
        // win[0] is newer row (y+1), win[2] older (y-1); bit 0 newest column (x+1)
        n0 = win[2][2] & !cy_lo & !cx_lo;
        n1 = win[2][1] & !cy_lo;
        n2 = win[2][0] & !cy_lo & !cx_hi;
        n3 = win[1][2] & !cx_lo;
        n5 = win[1][0] & !cx_hi;
        n6 = win[0][2] & !cy_hi & !cx_lo;
        n7 = win[0][1] & !cy_hi;
        n8 = win[0][0] & !cy_hi & !cx_hi;
        ncount = 4'(n0) + 4'(n1) + 4'(n2) + 4'(n3) + 4'(n5) + 4'(n6) + 4'(n7) + 4'(n8);
    end

    logic       c_live, born, dies;
    logic [FadeW-1:0] cur_fade, new_fade;
    logic [FadeW-1:0] r_cur_fade;

    // fade of the next centre fetched into a register ahead of its update
    always_ff @(posedge i_clk) begin
        if (r_state == S_SWEEP && cpos < PosW'(Cells)) begin
            r_cur_fade <= fade_mem[cpos[AddrW-1:0]];
        end
    end

    assign c_live = win[1][1];
    assign born   = r_cv && !c_live && (ncount == 4'd3);
    assign dies   = r_cv && c_live && (ncount != 4'd3) && (ncount != 4'd2);
    assign cur_fade = r_cur_fade;
    always_comb begin
        if (born || dies) begin
            new_fade = i_fade_bright;
        end else if (cur_fade > i_fade_dark) begin
            new_fade = cur_fade - FadeW'(1);
        end else begin
            new_fade = i_fade_dark;
        end
    end

    assign fin = (r_state == S_SWEEP) && (r_pos == EndPos);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == AddrW'(Cells - 1)) n_state = S_IDLE;
            S_IDLE:   if (in_ch.valid && in_ch.ready) n_state = S_ACCESS;
            S_ACCESS: begin
                if (r_req.command == CMD_STEP) n_state = S_SETTLE;
                else n_state = S_OUT;
            end
            S_SETTLE: if (r_pos == PosW'(Cells)) n_state = S_SWEEP;
            S_SWEEP:  if (fin) n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pos       <= '0;
            r_births    <= '0;
            r_deaths    <= '0;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
            r_cv        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_ch.valid && out_ch.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + AddrW'(1);
                S_IDLE: begin
                    r_pos  <= '0;
                    r_rd_v <= 1'b0;
                    r_cv   <= 1'b0;
                end
                S_ACCESS: begin
                    r_pos <= '0;
                end
                S_SETTLE: begin
                    r_pos  <= (r_pos == PosW'(Cells)) ? '0 : r_pos + PosW'(1);
                    r_rd_v <= (r_pos != PosW'(Cells));
                end
                S_SWEEP: begin
                    r_pos  <= r_pos + PosW'(1);
                    r_rd_v <= 1'b1;
                    r_cv   <= (r_pos >= Lag + PosW'(1)) && (cpos < PosW'(Cells));
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
            if (fin) begin
                r_births <= r_bcnt;
                r_deaths <= r_dcnt;
            end
        end
    end

    // counters and centre coordinates
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACCESS) begin
            r_bcnt <= '0;
            r_dcnt <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_caddr <= '0;
            r_lx   <= '0;
        end else if (r_state == S_SWEEP) begin
            if (born && r_bcnt != CountMax) r_bcnt <= r_bcnt + CountW'(1);
            if (dies && r_dcnt != CountMax) r_dcnt <= r_dcnt + CountW'(1);
            r_lx <= lx_next;
            if (r_cv) begin
                r_caddr <= r_caddr + AddrW'(1);
                if (32'(r_cx) == BOARD_WIDTH - 1) begin
                    r_cx <= '0;
                    r_cy <= r_cy + YW'(1);
                end else begin
                    r_cx <= r_cx + XW'(1);
                end
            end
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            cell_mem[r_clr] <= ST_DEAD;
            fade_mem[r_clr] <= '0;
        end else if (r_state == S_ACCESS && r_req.command == CMD_WRITE && on_board) begin
            cell_mem[req_addr] <= r_req.cell_alive ? ST_LIVE : ST_DEAD;
            fade_mem[req_addr] <= i_fade_dark;
        end else if (r_state == S_SETTLE && r_rd_v) begin
            cell_mem[AddrW'(r_pos - PosW'(1))] <=
                (r_rd_cell == ST_LIVE || r_rd_cell == ST_NEWBORN) ? ST_LIVE : ST_DEAD;
            snap_mem[AddrW'(r_pos - PosW'(1))] <=
                (r_rd_cell == ST_LIVE || r_rd_cell == ST_NEWBORN);
        end else if (r_state == S_SWEEP && r_cv) begin
            fade_mem[r_caddr] <= new_fade;
            if (born) cell_mem[r_caddr] <= ST_NEWBORN;
            else if (dies) cell_mem[r_caddr] <= ST_DYING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            r_req <= in_ch.payload;
        end
        if (r_state == S_OUT) begin
            r_out.births     <= (r_req.command == CMD_STEP) ? r_births : r_births;
            r_out.deaths     <= r_deaths;
            r_out.cell_state <= (r_req.command == CMD_READ && on_board) ? r_rd_cell : 2'd0;
            r_out.fade_level <= (r_req.command == CMD_READ && on_board) ? r_rd_fade : '0;
        end
    end
endmodule

[src/life_automaton_generation_core.sv]
// ----------------------------------------------------------------------------
// life_automaton_generation_core
// B3/S23 life board with per-cell fade levels, swept through a cell chain
// ----------------------------------------------------------------------------
// channel  direction  fields
// in       sink       command, cell_x, cell_y, cell_alive
// out      source     cell_state, fade_level, births, deaths
// cfg      write      fade_bright (0), fade_dark (1)
//
// read, write and unused commands: result valid after the access and output states
// step: settle pass then window sweep, one cell per cycle through
// the board memories
// after reset a clearing pass over all W*H cells runs before the first transaction
// the input is held off while a result waits on the output
// ----------------------------------------------------------------------------
module life_automaton_generation_core #(
    parameter int unsigned BOARD_WIDTH  = lag_pkg::BoardWidthDefault,
    parameter int unsigned BOARD_HEIGHT = lag_pkg::BoardHeightDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lag_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [lag_pkg::FadeW-1:0]    i_cfg_data,
    lag_if.sink                          in_ch,
    lag_if.source                        out_ch
);
    import lag_pkg::*;

    logic [FadeW-1:0] r_fade_bright, r_fade_dark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_bright <= 8'd255;
            r_fade_dark   <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FADE_BRIGHT: r_fade_bright <= i_cfg_data;
                REG_FADE_DARK:   r_fade_dark   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lag_core #(
        .BOARD_WIDTH  (BOARD_WIDTH),
        .BOARD_HEIGHT (BOARD_HEIGHT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fade_bright (r_fade_bright),
        .i_fade_dark   (r_fade_dark),
        .in_ch         (in_ch),
        .out_ch        (out_ch)
    );
endmodule

[src/lag_checker.sv]
// ----------------------------------------------------------------------------
// lag_checker
// port-level checks of the generation block
// ----------------------------------------------------------------------------
module lag_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_state,
    input logic [7:0] out_fade
);
    property p_no_overlap;
        @(posedge i_clk) disable iff (!i_rst_n) out_valid |-> !in_ready;
    endproperty
    a_no_overlap: assert property (p_no_overlap) else $error("input open while result waits");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n) out_valid && !out_ready |=> out_valid;
    endproperty
    a_hold: assert property (p_hold) else $error("result dropped");

    property p_one;
        @(posedge i_clk) disable iff (!i_rst_n) in_valid && in_ready |=> !in_ready;
    endproperty
    a_one: assert property (p_one) else $error("second transaction taken early");

    property p_stable;
        @(posedge i_clk) disable iff (!i_rst_n)
            out_valid && !out_ready |=> $stable(out_state) && $stable(out_fade);
    endproperty
    a_stable: assert property (p_stable) else $error("waiting result changed");
endmodule

bind life_automaton_generation_core lag_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_state (out_ch.payload.cell_state),
    .out_fade  (out_ch.payload.fade_level)
);
